// ----- src/kcl_pkg.sv -----
// ----------------------------------------------------------------------------
// Keypad code lock package
// Key codes, status codes, phase encoding and sizing shared by the lock and
// its port checker.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // Number of keys in one code (legal range 1 to 8).
  localparam int CODE_LENGTH = 4;
  localparam int SLOT_W      = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int MATCH_W     = $clog2(CODE_LENGTH + 1);

  localparam logic [7:0] KEY_ENTER  = 8'd13;
  localparam logic [7:0] KEY_CLEAR  = 8'd76;   // 'L'
  localparam logic [7:0] KEY_CANCEL = 8'd67;   // 'C'
  localparam logic [7:0] KEY_ACCESS = 8'd1;
  localparam logic [7:0] KEY_CHANGE = 8'd2;

  localparam logic [3:0] ST_IGNORED   = 4'd0;
  localparam logic [3:0] ST_INVALID   = 4'd1;
  localparam logic [3:0] ST_TAKEN     = 4'd2;
  localparam logic [3:0] ST_CLEARED   = 4'd3;
  localparam logic [3:0] ST_CANCELLED = 4'd4;
  localparam logic [3:0] ST_WRONG     = 4'd5;
  localparam logic [3:0] ST_GRANTED   = 4'd6;
  localparam logic [3:0] ST_OLD_OK    = 4'd7;
  localparam logic [3:0] ST_CHANGED   = 4'd8;
  localparam logic [3:0] ST_MODE      = 4'd9;

  // Phase codes as shown on the phase_now port.
  localparam logic [2:0] PC_MENU        = 3'd0;
  localparam logic [2:0] PC_ACC_ENTRY   = 3'd1;
  localparam logic [2:0] PC_ACC_CONFIRM = 3'd2;
  localparam logic [2:0] PC_OLD_ENTRY   = 3'd3;
  localparam logic [2:0] PC_OLD_CONFIRM = 3'd4;
  localparam logic [2:0] PC_NEW_ENTRY   = 3'd5;
  localparam logic [2:0] PC_NEW_CONFIRM = 3'd6;

  typedef enum logic [6:0] {
    PH_MENU        = 7'b0000001,
    PH_ACC_ENTRY   = 7'b0000010,
    PH_ACC_CONFIRM = 7'b0000100,
    PH_OLD_ENTRY   = 7'b0001000,
    PH_OLD_CONFIRM = 7'b0010000,
    PH_NEW_ENTRY   = 7'b0100000,
    PH_NEW_CONFIRM = 7'b1000000
  } phase_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_ACC_ENTRY:   code = PC_ACC_ENTRY;
      PH_ACC_CONFIRM: code = PC_ACC_CONFIRM;
      PH_OLD_ENTRY:   code = PC_OLD_ENTRY;
      PH_OLD_CONFIRM: code = PC_OLD_CONFIRM;
      PH_NEW_ENTRY:   code = PC_NEW_ENTRY;
      PH_NEW_CONFIRM: code = PC_NEW_CONFIRM;
      default:        code = PC_MENU;
    endcase
    return code;
  endfunction

endpackage

// ----- src/keypad_code_lock.sv -----
// ----------------------------------------------------------------------------
// Keypad code lock
// Menu-driven code lock: door access and code change dialogues over a
// stream of key codes, one result word per key word.
// ----------------------------------------------------------------------------
// Usage:
//   Key channel (key_valid/key_ready/key_code) carries one key code per word.
//   Result channel (result_valid/result_ready) carries status, phase_now,
//   echo_digit and door_open for every key word, in order.
//   Result: registered, valid in the cycle after its key word is taken.
//   Throughput: one key word per cycle while result_ready is high. The lock
//   state and the result register load together on the accepting edge; the
//   only path is one slot compare plus the phase update.
//   Stall: while a result word waits, a new key word is taken only in the
//   same cycle the waiting word leaves (key_ready = !result_valid ||
//   result_ready), so no word is lost or repeated.
//   Reset (rst, synchronous): returns to the menu, clears slot and match
//   counters, sets the stored code to all zeros and drops result_valid.
//   door_open is a field of the result word: high on exactly the word that
//   grants access.
// ----------------------------------------------------------------------------
module keypad_code_lock (
  input  logic       clk,
  input  logic       rst,
  input  logic       key_valid,
  output logic       key_ready,
  input  logic [7:0] key_code,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [3:0] status,
  output logic [2:0] phase_now,
  output logic [7:0] echo_digit,
  output logic       door_open
);

  // Lock state
  kcl_pkg::phase_t                    phase, phase_next;
  logic [kcl_pkg::SLOT_W-1:0]         slot_index, slot_next;
  logic [kcl_pkg::MATCH_W-1:0]        match_count, match_next;
  logic [7:0]                         stored_code  [kcl_pkg::CODE_LENGTH];
  logic [7:0]                         pending_code [kcl_pkg::CODE_LENGTH];

  // Per-key decisions
  logic       accept;
  logic       slot_last;
  logic       pend_we;
  logic       store_load;
  logic [3:0] status_next;
  logic [7:0] echo_next;
  logic       door_next;

  // The result register parts the two channels: take a key whenever the
  // result slot is empty or being drained this cycle.
  assign key_ready = !result_valid || result_ready;
  assign accept    = key_valid && key_ready;
  assign slot_last = (slot_index == kcl_pkg::SLOT_W'(kcl_pkg::CODE_LENGTH - 1));

  always_comb begin
    phase_next  = phase;
    slot_next   = slot_index;
    match_next  = match_count;
    status_next = kcl_pkg::ST_IGNORED;
    echo_next   = '0;
    door_next   = 1'b0;
    pend_we     = 1'b0;
    store_load  = 1'b0;
    case (phase)
      kcl_pkg::PH_ACC_ENTRY, kcl_pkg::PH_OLD_ENTRY, kcl_pkg::PH_NEW_ENTRY: begin
        if (key_code == kcl_pkg::KEY_CLEAR) begin
          // restart this entry from the first slot
          slot_next   = '0;
          match_next  = '0;
          status_next = kcl_pkg::ST_CLEARED;
        end else if (key_code == kcl_pkg::KEY_CANCEL) begin
          phase_next  = kcl_pkg::PH_MENU;
          slot_next   = '0;
          match_next  = '0;
          status_next = kcl_pkg::ST_CANCELLED;
        end else begin
          // Enter mid-entry fills the slot but can never count as a match;
          // in new entry it is stored as-is.
          if (phase == kcl_pkg::PH_NEW_ENTRY) begin
            pend_we = 1'b1;
          end else if (key_code != kcl_pkg::KEY_ENTER &&
                       stored_code[slot_index] == key_code) begin
            match_next = match_count + kcl_pkg::MATCH_W'(1);
          end
          if (key_code != kcl_pkg::KEY_ENTER) begin
            echo_next = key_code;
          end
          status_next = kcl_pkg::ST_TAKEN;
          if (slot_last) begin
            // last slot filled: advance to the matching confirm phase
            slot_next = '0;
            if (phase == kcl_pkg::PH_ACC_ENTRY) begin
              phase_next = kcl_pkg::PH_ACC_CONFIRM;
            end else if (phase == kcl_pkg::PH_OLD_ENTRY) begin
              phase_next = kcl_pkg::PH_OLD_CONFIRM;
            end else begin
              phase_next = kcl_pkg::PH_NEW_CONFIRM;
            end
          end else begin
            slot_next = slot_index + kcl_pkg::SLOT_W'(1);
          end
        end
      end
      kcl_pkg::PH_ACC_CONFIRM, kcl_pkg::PH_OLD_CONFIRM, kcl_pkg::PH_NEW_CONFIRM: begin
        if (key_code == kcl_pkg::KEY_CLEAR) begin
          slot_next   = '0;
          match_next  = '0;
          status_next = kcl_pkg::ST_CLEARED;
          if (phase == kcl_pkg::PH_ACC_CONFIRM) begin
            phase_next = kcl_pkg::PH_ACC_ENTRY;
          end else if (phase == kcl_pkg::PH_OLD_CONFIRM) begin
            phase_next = kcl_pkg::PH_OLD_ENTRY;
          end else begin
            phase_next = kcl_pkg::PH_NEW_ENTRY;
          end
        end else if (key_code == kcl_pkg::KEY_CANCEL) begin
          phase_next  = kcl_pkg::PH_MENU;
          slot_next   = '0;
          match_next  = '0;
          status_next = kcl_pkg::ST_CANCELLED;
        end else if (key_code == kcl_pkg::KEY_ENTER) begin
          slot_next  = '0;
          match_next = '0;
          if (phase == kcl_pkg::PH_NEW_CONFIRM) begin
            // commit the new code; it takes effect at once
            store_load  = 1'b1;
            phase_next  = kcl_pkg::PH_MENU;
            status_next = kcl_pkg::ST_CHANGED;
          end else if (match_count != kcl_pkg::MATCH_W'(kcl_pkg::CODE_LENGTH)) begin
            status_next = kcl_pkg::ST_WRONG;
            phase_next  = (phase == kcl_pkg::PH_ACC_CONFIRM) ?
                          kcl_pkg::PH_ACC_ENTRY : kcl_pkg::PH_OLD_ENTRY;
          end else if (phase == kcl_pkg::PH_ACC_CONFIRM) begin
            phase_next  = kcl_pkg::PH_MENU;
            status_next = kcl_pkg::ST_GRANTED;
            door_next   = 1'b1;
          end else begin
            phase_next  = kcl_pkg::PH_NEW_ENTRY;
            status_next = kcl_pkg::ST_OLD_OK;
          end
        end
        // any other key: hold everything, report ignored
      end
      default: begin
        // menu, and any stray phase value, behaves as the menu
        slot_next  = '0;
        match_next = '0;
        if (key_code == kcl_pkg::KEY_ACCESS) begin
          phase_next  = kcl_pkg::PH_ACC_ENTRY;
          status_next = kcl_pkg::ST_MODE;
        end else if (key_code == kcl_pkg::KEY_CHANGE) begin
          phase_next  = kcl_pkg::PH_OLD_ENTRY;
          status_next = kcl_pkg::ST_MODE;
        end else begin
          phase_next  = kcl_pkg::PH_MENU;
          status_next = kcl_pkg::ST_INVALID;
        end
      end
    endcase
  end

  // Control state and stored code
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= kcl_pkg::PH_MENU;
      slot_index   <= '0;
      match_count  <= '0;
      result_valid <= 1'b0;
      for (int k = 0; k < kcl_pkg::CODE_LENGTH; k++) begin
        stored_code[k] <= '0;
      end
    end else begin
      if (accept) begin
        phase       <= phase_next;
        slot_index  <= slot_next;
        match_count <= match_next;
        if (store_load) begin
          for (int k = 0; k < kcl_pkg::CODE_LENGTH; k++) begin
            stored_code[k] <= pending_code[k];
          end
        end
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Pending code and result word: payload only, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      if (pend_we) begin
        pending_code[slot_index] <= key_code;
      end
      status     <= status_next;
      phase_now  <= kcl_pkg::phase_code(phase_next);
      echo_digit <= echo_next;
      door_open  <= door_next;
    end
  end

endmodule

// ----- src/kcl_checker.sv -----
// ----------------------------------------------------------------------------
// Keypad code lock port checker
// Watches the lock's ports for result words that contradict each other or
// change while stalled.
// ----------------------------------------------------------------------------
module kcl_checker (
  input logic       clk,
  input logic       rst,
  input logic       key_valid,
  input logic       key_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [3:0] status,
  input logic [2:0] phase_now,
  input logic [7:0] echo_digit,
  input logic       door_open
);

  // A granted word opens the door and lands back in the menu.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && door_open |->
      status == kcl_pkg::ST_GRANTED && phase_now == kcl_pkg::PC_MENU)
    else $error("door_open without a granted status in the menu");

  // A mode key always lands in the first entry phase of a dialogue.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && status == kcl_pkg::ST_MODE |->
      phase_now == kcl_pkg::PC_ACC_ENTRY || phase_now == kcl_pkg::PC_OLD_ENTRY)
    else $error("mode entered without landing in an entry phase");

  // Only a taken digit echoes anything.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && echo_digit != 8'd0 |-> status == kcl_pkg::ST_TAKEN)
    else $error("echo_digit set on a word that took no digit");

  // Key accepted now means a result word on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    key_valid && key_ready |=> result_valid)
    else $error("accepted key produced no result word");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(status) && $stable(phase_now) &&
      $stable(echo_digit) && $stable(door_open))
    else $error("stalled result word changed");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (.*);
